// File: hw/rtl/isort_pkg.sv
// isort_pkg: sizes, types and sequencer states shared by the insertion sorter.
// No dependencies; the other files in hw/rtl, except isort_ram, refer to it by scoped name.

package isort_pkg;

  // Store capacity and derived widths
  localparam int DEPTH  = 64;
  localparam int DATA_W = 32;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic [CNT_W-1:0]         cnt_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_SHIFT,
    ST_PLACE,
    ST_DRAIN_RD,
    ST_DRAIN_LD
  } state_t;

  // Store access request from the sequencer
  typedef struct packed {
    logic  we;
    addr_t waddr;
    data_t wdata;
    logic  re;
    addr_t raddr;
  } mem_req_t;

  // One result beat handed to the output register
  typedef struct packed {
    data_t value;
    logic  last;
    logic  ovf;
  } beat_t;

endpackage

// File: hw/rtl/isort_ram.sv
// isort_ram: generic single-write, single-read RAM with registered read data.
// Stand-alone; no package dependency.

module isort_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AddrW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AddrW-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/isort_seq.sv
// isort_seq: sequencer for insertion and drain, with the shared signed comparator.
// Depends on isort_pkg; drives the list store through a mem_req_t request.

module isort_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  isort_pkg::data_t    element,
  input  logic                is_final,
  output isort_pkg::mem_req_t mem_req,
  input  isort_pkg::data_t    mem_rdata,
  input  logic                out_free,
  output logic                load,
  output isort_pkg::beat_t    load_beat
);

  isort_pkg::state_t state, state_next;
  isort_pkg::cnt_t   fill, fill_next;
  logic              dropped, dropped_next;
  isort_pkg::addr_t  pos, pos_next;
  isort_pkg::addr_t  k, k_next;
  isort_pkg::data_t  value, value_next;
  logic              fin, fin_next;

  logic full;
  logic greater;
  logic drain_last;

  assign full       = (fill == isort_pkg::CNT_W'(isort_pkg::DEPTH));
  // the one compare unit: stored entry strictly above the new element
  assign greater    = (mem_rdata > value);
  assign drain_last = ((isort_pkg::CNT_W'(k) + isort_pkg::CNT_W'(1)) == fill);

  // State and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= isort_pkg::ST_IDLE;
      fill    <= '0;
      dropped <= 1'b0;
    end else begin
      state   <= state_next;
      fill    <= fill_next;
      dropped <= dropped_next;
    end
  end

  // Working registers, always set before use
  always_ff @(posedge clk) begin
    pos   <= pos_next;
    k     <= k_next;
    value <= value_next;
    fin   <= fin_next;
  end

  // Next state and store/output control
  always_comb begin
    state_next   = state;
    fill_next    = fill;
    dropped_next = dropped;
    pos_next     = pos;
    k_next       = k;
    value_next   = value;
    fin_next     = fin;
    item_stall   = (state != isort_pkg::ST_IDLE);
    mem_req      = '0;
    load         = 1'b0;
    load_beat.value = mem_rdata;
    load_beat.last  = drain_last;
    load_beat.ovf   = dropped;

    case (state)
      isort_pkg::ST_IDLE: begin
        if (item_valid) begin
          value_next = element;
          fin_next   = is_final;
          if (full) begin
            // store full: drop, remember it
            dropped_next = 1'b1;
            if (is_final) begin
              k_next     = '0;
              state_next = isort_pkg::ST_DRAIN_RD;
            end
          end else begin
            pos_next   = fill[isort_pkg::ADDR_W-1:0];
            state_next = (fill == '0) ? isort_pkg::ST_PLACE : isort_pkg::ST_FETCH;
          end
        end
      end

      isort_pkg::ST_FETCH: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = pos - isort_pkg::ADDR_W'(1);
        state_next    = isort_pkg::ST_SHIFT;
      end

      isort_pkg::ST_SHIFT: begin
        if (greater) begin
          // move the larger entry up one place, fetch the one below if there is one
          mem_req.we    = 1'b1;
          mem_req.waddr = pos;
          mem_req.wdata = mem_rdata;
          pos_next      = pos - isort_pkg::ADDR_W'(1);
          if (pos == isort_pkg::ADDR_W'(1)) begin
            state_next = isort_pkg::ST_PLACE;
          end else begin
            mem_req.re    = 1'b1;
            mem_req.raddr = pos - isort_pkg::ADDR_W'(1) - isort_pkg::ADDR_W'(1);
          end
        end else begin
          state_next = isort_pkg::ST_PLACE;
        end
      end

      isort_pkg::ST_PLACE: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = pos;
        mem_req.wdata = value;
        fill_next     = fill + isort_pkg::CNT_W'(1);
        if (fin) begin
          k_next     = '0;
          state_next = isort_pkg::ST_DRAIN_RD;
        end else begin
          state_next = isort_pkg::ST_IDLE;
        end
      end

      isort_pkg::ST_DRAIN_RD: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = k;
        state_next    = isort_pkg::ST_DRAIN_LD;
      end

      isort_pkg::ST_DRAIN_LD: begin
        if (out_free) begin
          load = 1'b1;
          if (drain_last) begin
            fill_next    = '0;
            dropped_next = 1'b0;
            state_next   = isort_pkg::ST_IDLE;
          end else begin
            k_next     = k + isort_pkg::ADDR_W'(1);
            state_next = isort_pkg::ST_DRAIN_RD;
          end
        end
      end

      default: begin
        state_next = isort_pkg::ST_IDLE;
      end
    endcase
  end

  // Shift step never reads and writes the same entry
  a_no_collide: assert property (@(posedge clk) disable iff (rst)
    (mem_req.we && mem_req.re) |-> (mem_req.waddr != mem_req.raddr))
    else $error("store read and write hit the same entry");

  // Placing an element grows the list by exactly one
  a_place_count: assert property (@(posedge clk) disable iff (rst)
    (state == isort_pkg::ST_PLACE) |=> (fill == $past(fill) + isort_pkg::CNT_W'(1)))
    else $error("fill count not advanced on placement");

  // Final beat of a list leaves an empty list
  a_drain_clears: assert property (@(posedge clk) disable iff (rst)
    (load && load_beat.last) |=> (fill == '0 && !dropped && state == isort_pkg::ST_IDLE))
    else $error("list not cleared after final beat");

endmodule

// File: hw/rtl/isort_outreg.sv
// isort_outreg: result output register with valid/stall handshake.
// Depends on isort_pkg for the beat_t type.

module isort_outreg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  isort_pkg::beat_t load_beat,
  output logic             free,
  output logic             result_valid,
  input  logic             result_stall,
  output isort_pkg::data_t sorted_value,
  output logic             end_of_list,
  output logic             overflowed
);

  // room for a new beat when empty or being taken now
  assign free = !result_valid || !result_stall;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (load) begin
      sorted_value <= load_beat.value;
      end_of_list  <= load_beat.last;
      overflowed   <= load_beat.ovf;
    end
  end

  // A held beat is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> (!result_valid || !result_stall))
    else $error("output beat overwritten while stalled");

endmodule

// File: hw/rtl/insertion_sorter.sv
// insertion_sorter: top level of the stable insertion sorter.
// Depends on isort_pkg, isort_ram, isort_seq and isort_outreg.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+-------------------------------------
//   item     | item_valid / item_stall    | element, is_final
//   result   | result_valid / result_stall| sorted_value, end_of_list, overflowed
//
// An element is placed by fetching the entry below its slot, moving each
// larger entry (up to DEPTH-1) up one place, then writing it in; into an
// empty list it is written directly. At most one store read and one write
// per cycle on the RAM ports. An element offered to a full store is dropped.
// Closing an n-entry list drains it beat by beat: a store read, then a load.
// Synchronous reset empties the list; the store contents are not cleared.
// result_stall holds the output register; the drain waits on it, and a new
// item is taken while the last beat still waits.

module insertion_sorter (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  isort_pkg::data_t element,
  input  logic             is_final,
  output logic             result_valid,
  input  logic             result_stall,
  output isort_pkg::data_t sorted_value,
  output logic             end_of_list,
  output logic             overflowed
);

  isort_pkg::mem_req_t mem_req;
  isort_pkg::data_t    mem_rdata;
  isort_pkg::beat_t    load_beat;
  logic                load;
  logic                out_free;

  // Sequencer with the shared comparator
  isort_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .element    (element),
    .is_final   (is_final),
    .mem_req    (mem_req),
    .mem_rdata  (mem_rdata),
    .out_free   (out_free),
    .load       (load),
    .load_beat  (load_beat)
  );

  // Sorted list store
  isort_ram #(
    .WIDTH (isort_pkg::DATA_W),
    .DEPTH (isort_pkg::DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

  // Result output register
  isort_outreg u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (load),
    .load_beat    (load_beat),
    .free         (out_free),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .sorted_value (sorted_value),
    .end_of_list  (end_of_list),
    .overflowed   (overflowed)
  );

endmodule
